>>> rtl/core/sft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_pkg
// Types and constants shared by the stuffed frame transmitter modules.
// ----------------------------------------------------------------------------
package sft_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_FLAG      = 3'd0;
    localparam logic [2:0] REG_ESCAPE    = 3'd1;
    localparam logic [2:0] REG_FLAG_SUB  = 3'd2;
    localparam logic [2:0] REG_ESC_SUB   = 3'd3;
    localparam logic [2:0] REG_ADDRESS   = 3'd4;
    localparam logic [2:0] REG_CTRL_ZERO = 3'd5;
    localparam logic [2:0] REG_CTRL_ONE  = 3'd6;

    // Reset values of the registers
    localparam logic [7:0] RST_FLAG      = 8'h7e;
    localparam logic [7:0] RST_ESCAPE    = 8'h7d;
    localparam logic [7:0] RST_FLAG_SUB  = 8'h5e;
    localparam logic [7:0] RST_ESC_SUB   = 8'h5d;
    localparam logic [7:0] RST_ADDRESS   = 8'h03;
    localparam logic [7:0] RST_CTRL_ZERO = 8'h00;
    localparam logic [7:0] RST_CTRL_ONE  = 8'h40;

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
        logic [7:0] flag_substitute;
        logic [7:0] escape_substitute;
        logic [7:0] address_value;
        logic [7:0] control_seq_zero;
        logic [7:0] control_seq_one;
    } cfg_t;

    // One classified item passed from front to back
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] check_byte;    // running XOR including this byte
        logic       first_byte;    // opens a frame: header goes first
        logic       final_byte;    // closes the frame: check and flag follow
        logic       sequence_bit;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HCS,
        PH_DATA,
        PH_PCS,
        PH_CLOSE
    } phase_t;

endpackage

>>> rtl/core/sft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_front
// Accepts payload items, tracks frame state and the running payload check,
// and pushes one classified command per item into the queue.
// ----------------------------------------------------------------------------
module sft_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_payload_byte,
    input  logic          s_final_byte,
    input  logic          s_sequence_bit,
    input  logic          queue_full,
    output logic          push,
    output sft_pkg::cmd_t push_cmd
);
    import sft_pkg::*;

    logic       inside_frame_reg, inside_frame_next;
    logic [7:0] check_reg, check_next;
    logic [7:0] check_base;
    logic [7:0] check_sum;

    assign s_ready    = !queue_full;
    assign push       = s_valid && !queue_full;
    assign check_base = inside_frame_reg ? check_reg : 8'h00;
    assign check_sum  = check_base ^ s_payload_byte;

    always_comb begin
        push_cmd.payload_byte = s_payload_byte;
        push_cmd.check_byte   = check_sum;
        push_cmd.first_byte   = !inside_frame_reg;
        push_cmd.final_byte   = s_final_byte;
        push_cmd.sequence_bit = s_sequence_bit;
    end

    always_comb begin
        inside_frame_next = inside_frame_reg;
        check_next        = check_reg;
        if (push) begin
            inside_frame_next = !s_final_byte;
            check_next        = s_final_byte ? 8'h00 : check_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_frame_reg <= 1'b0;
            check_reg        <= 8'h00;
        end else begin
            inside_frame_reg <= inside_frame_next;
            check_reg        <= check_next;
        end
    end

endmodule

>>> rtl/core/sft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module sft_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sft_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sft_pkg::cmd_t head_cmd
);
    import sft_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

>>> rtl/core/sft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_back
// Walks each queued command through header, stuffed payload and trailer,
// one line byte per cycle while a command waits and the receiver accepts,
// into the output register.
module sft_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  sft_pkg::cfg_t cfg,
    input  logic          head_valid,
    input  sft_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_line_byte,
    output logic          m_run_last,
    output logic          m_frame_closed
);
    import sft_pkg::*;

    phase_t     phase_reg, phase_next, cur_phase;
    logic       sub_reg, sub_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] line_byte_reg;
    logic       run_last_reg;
    logic       frame_closed_reg;

    logic       step;
    logic [7:0] ctrl_byte;
    logic [7:0] cur_byte;
    logic       is_flag;
    logic       is_esc;
    logic       unit_done;      // last byte of the current (possibly stuffed) unit
    logic [7:0] stuffed_byte;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_closed;

    assign step      = head_valid && (!m_valid_reg || m_ready);
    assign ctrl_byte = head_cmd.sequence_bit ? cfg.control_seq_one : cfg.control_seq_zero;
    assign is_flag   = (cur_byte == cfg.flag_value);
    assign is_esc    = !is_flag && (cur_byte == cfg.escape_value);

    always_comb begin
        cur_phase = phase_reg;
        if (phase_reg == PH_START) begin
            cur_phase = head_cmd.first_byte ? PH_FLAG : PH_DATA;
        end
    end

    always_comb begin
        unique case (cur_phase)
            PH_HCS:  cur_byte = cfg.address_value ^ ctrl_byte;
            PH_PCS:  cur_byte = head_cmd.check_byte;
            default: cur_byte = head_cmd.payload_byte;
        endcase
    end

    // Stuffing: escape first, then the substitute
    always_comb begin
        priority if (sub_reg) begin
            stuffed_byte = is_flag ? cfg.flag_substitute : cfg.escape_substitute;
            unit_done    = 1'b1;
        end else if (is_flag || is_esc) begin
            stuffed_byte = cfg.escape_value;
            unit_done    = 1'b0;
        end else begin
            stuffed_byte = cur_byte;
            unit_done    = 1'b1;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        sub_next   = sub_reg;
        pop        = 1'b0;
        out_byte   = stuffed_byte;
        out_last   = 1'b0;
        out_closed = 1'b0;
        unique case (cur_phase)
            PH_START: begin
                out_byte = stuffed_byte;
            end
            PH_FLAG: begin
                out_byte = cfg.flag_value;
                if (step) phase_next = PH_ADDR;
            end
            PH_ADDR: begin
                out_byte = cfg.address_value;
                if (step) phase_next = PH_CTRL;
            end
            PH_CTRL: begin
                out_byte = ctrl_byte;
                if (step) phase_next = PH_HCS;
            end
            PH_HCS: begin
                if (step) begin
                    sub_next   = !unit_done;
                    phase_next = unit_done ? PH_DATA : PH_HCS;
                end
            end
            PH_DATA: begin
                out_last = unit_done && !head_cmd.final_byte;
                if (step) begin
                    sub_next = !unit_done;
                    if (unit_done) begin
                        phase_next = head_cmd.final_byte ? PH_PCS : PH_START;
                        pop        = !head_cmd.final_byte;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_PCS: begin
                if (step) begin
                    sub_next   = !unit_done;
                    phase_next = unit_done ? PH_CLOSE : PH_PCS;
                end
            end
            PH_CLOSE: begin
                out_byte   = cfg.flag_value;
                out_last   = 1'b1;
                out_closed = 1'b1;
                if (step) begin
                    phase_next = PH_START;
                    pop        = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            sub_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            sub_reg     <= sub_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            line_byte_reg    <= out_byte;
            run_last_reg     <= out_last;
            frame_closed_reg <= out_closed;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_line_byte    = line_byte_reg;
    assign m_run_last     = run_last_reg;
    assign m_frame_closed = frame_closed_reg;

`ifndef SYNTHESIS
    a_closed_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && frame_closed_reg) |-> run_last_reg)
        else $error("closing flag not marked as last byte of item");
    a_sub_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> (phase_reg == PH_HCS || phase_reg == PH_DATA || phase_reg == PH_PCS))
        else $error("stuffing pending outside a stuffed field");
    a_close_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && cur_phase == PH_CLOSE) |=> (phase_reg == PH_START && !sub_reg))
        else $error("sequencer did not restart after closing flag");
`endif

endmodule

>>> rtl/core/stuffed_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_transmitter
// Framer: turns payload bytes into byte-stuffed information frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one payload byte per item, with s_final_byte marking
//   the last byte of a frame and s_sequence_bit picking the control byte on
//   the first byte. Output channel m_*: one line byte per item; m_run_last
//   marks the last line byte caused by an input item, m_frame_closed the
//   closing flag. APB port: seven 8-bit registers at byte addresses 4*i;
//   write them only while the block is idle.
//   Throughput: the back end emits one line byte per cycle while the receiver
//   accepts it. An input item causes 1 line byte for a plain mid-frame
//   byte, 2 when stuffed, plus 4 or 5 for a frame header and 2 to 3 for the
//   trailer. The front end keeps taking items while the command queue has
//   room, so header and trailer bursts are absorbed by the queue.
//   Input to output: with the back end idle, an accepted item is written into
//   the queue first, and its first line byte is then registered for output.
//   Reset (aresetn low, synchronous): no frame open, queue and output empty,
//   registers back to their defaults.
//   Receiver stall: the output register holds its byte; the back end waits,
//   the queue fills and then s_ready drops.
// ----------------------------------------------------------------------------
module stuffed_frame_transmitter #(
    parameter int QUEUE_DEPTH = 4     // queued items, 2 or more
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_final_byte,
    input  logic        s_sequence_bit,
    // result item channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_line_byte,
    output logic        m_run_last,
    output logic        m_frame_closed,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sft_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [2:0] reg_index;
    logic [7:0] rd_byte;

    logic       push;
    cmd_t       push_cmd;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    cmd_t       head_cmd;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_wr    = psel && penable && pwrite && pready;

    // Decode the write; drop writes beyond the last register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_index)
                REG_FLAG:      cfg_next.flag_value        = pwdata[7:0];
                REG_ESCAPE:    cfg_next.escape_value      = pwdata[7:0];
                REG_FLAG_SUB:  cfg_next.flag_substitute   = pwdata[7:0];
                REG_ESC_SUB:   cfg_next.escape_substitute = pwdata[7:0];
                REG_ADDRESS:   cfg_next.address_value     = pwdata[7:0];
                REG_CTRL_ZERO: cfg_next.control_seq_zero  = pwdata[7:0];
                REG_CTRL_ONE:  cfg_next.control_seq_one   = pwdata[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back; unmapped addresses read as zero
    always_comb begin
        unique case (reg_index)
            REG_FLAG:      rd_byte = cfg_reg.flag_value;
            REG_ESCAPE:    rd_byte = cfg_reg.escape_value;
            REG_FLAG_SUB:  rd_byte = cfg_reg.flag_substitute;
            REG_ESC_SUB:   rd_byte = cfg_reg.escape_substitute;
            REG_ADDRESS:   rd_byte = cfg_reg.address_value;
            REG_CTRL_ZERO: rd_byte = cfg_reg.control_seq_zero;
            REG_CTRL_ONE:  rd_byte = cfg_reg.control_seq_one;
            default:       rd_byte = 8'h00;
        endcase
    end

    assign prdata = {24'h000000, rd_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_value        <= RST_FLAG;
            cfg_reg.escape_value      <= RST_ESCAPE;
            cfg_reg.flag_substitute   <= RST_FLAG_SUB;
            cfg_reg.escape_substitute <= RST_ESC_SUB;
            cfg_reg.address_value     <= RST_ADDRESS;
            cfg_reg.control_seq_zero  <= RST_CTRL_ZERO;
            cfg_reg.control_seq_one   <= RST_CTRL_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- front: accept and classify items ----
    sft_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_final_byte   (s_final_byte),
        .s_sequence_bit (s_sequence_bit),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // ---- queue: decouple front from back ----
    sft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // ---- back: emit header, stuffed bytes and trailer ----
    sft_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_byte    (m_line_byte),
        .m_run_last     (m_run_last),
        .m_frame_closed (m_frame_closed)
    );

endmodule
